### design/sd_card_spi_mode_target_assert.svh
// assertion macros used by the checker file
`ifndef SD_CARD_SPI_MODE_TARGET_ASSERT_SVH
`define SD_CARD_SPI_MODE_TARGET_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SDST_AST_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SDST_AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sdst_pkg.sv
// shared types and constants of the spi-mode card target
package sdst_pkg;

    localparam longint unsigned STORE_BYTES_DEF = 64'd65536;
    localparam int unsigned     BLK             = 512;

    localparam logic [7:0] TOK_START  = 8'hFE;
    localparam logic [7:0] TOK_RD_ERR = 8'h09;
    localparam logic [7:0] DR_OK      = 8'h05;
    localparam logic [7:0] DR_WR_ERR  = 8'h0D;
    localparam logic [7:0] R1_IDLE    = 8'h01;
    localparam logic [7:0] R1_ILLEGAL = 8'h04;
    localparam logic [7:0] IDLE_BYTE  = 8'hFF;
    localparam logic [31:0] OCR_VALUE = 32'h00FF8000;

    // command indexes
    localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
    localparam logic [5:0] CMD_OP_COND  = 6'd1;
    localparam logic [5:0] CMD_BLK_LEN  = 6'd16;
    localparam logic [5:0] CMD_RD_SINGLE = 6'd17;
    localparam logic [5:0] CMD_WR_SINGLE = 6'd24;
    localparam logic [5:0] ACMD_OP_COND = 6'd41;
    localparam logic [5:0] CMD_APP      = 6'd55;
    localparam logic [5:0] CMD_RD_OCR   = 6'd58;

    typedef enum logic [3:0] {
        PH_CMD   = 4'b0001,
        PH_SEND  = 4'b0010,
        PH_TOKEN = 4'b0100,
        PH_DATA  = 4'b1000
    } t_phase;

    // store access from the protocol engine
    typedef struct packed {
        logic        we;
        logic [31:0] waddr;
        logic [7:0]  wdata;
        logic        re;
        logic [31:0] raddr;
    } t_mem_req;

endpackage

### design/sd_card_spi_mode_target.sv
// data_out for a pin sample is registered and appears the cycle after it is taken;
// store reads land in the cycle after a byte ends; one pin sample per cycle unless
// the store is busy or a word stalls; a reply byte from the store is fetched
// through the single registered read port; reset: synchronous active-low; the store
// is then swept to zero, one byte per cycle, and no pin sample is taken meanwhile
module sd_card_spi_mode_target #(
    parameter longint unsigned STORE_BYTES = sdst_pkg::STORE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,     // card_present
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // chip_select, serial_clock, data_in, zero fill
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // data_out, zero fill
);
    localparam logic [32:0] SB = 33'(STORE_BYTES);

    sdst_pkg::t_mem_req mem_req;
    logic [7:0] mem_rdata;
    logic       mem_busy;

    sdst_store #(.STORE_BYTES(STORE_BYTES)) u_store (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mem_req),
        .o_rdata(mem_rdata),
        .o_busy (mem_busy)
    );

    logic r_present, r_last_clk, r_out_level, r_idle, r_app, r_sblk, r_rd_pend;
    logic n_last_clk, n_out_level, n_idle, n_app, n_sblk, n_rd_pend;
    logic [2:0] r_bit_cnt, n_bit_cnt, r_cmd_cnt, n_cmd_cnt;
    logic [7:0] r_in_shift, n_in_shift, r_out_shift, n_out_shift;
    sdst_pkg::t_phase r_phase, n_phase, r_after, n_after;
    logic [7:0] r_cmd [0:5];
    logic [7:0] n_cmd [0:5];
    logic [7:0] r_sr [0:4];
    logic [7:0] n_sr [0:4];
    logic [9:0] r_pos, n_pos, r_len, n_len, r_dcnt, n_dcnt;
    logic [31:0] r_blk, n_blk;
    logic r_ovalid, r_odata;

    logic        accept, rise, byte_done, fits;
    logic [7:0]  in_byte, b;
    logic [5:0]  idx;
    logic [31:0] arg;
    logic [7:0]  r1v;
    logic [9:0]  pos_inc, pos_m2;
    logic [32:0] rd_addr, wr_addr, wr_end;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !mem_busy && (!r_ovalid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_odata};

    // protocol engine next state
    always_comb begin
        n_last_clk  = r_last_clk;
        n_out_level = r_out_level;
        n_bit_cnt   = r_bit_cnt;
        n_in_shift  = r_in_shift;
        n_out_shift = r_rd_pend ? mem_rdata : r_out_shift;
        n_phase     = r_phase;
        n_after     = r_after;
        n_cmd       = r_cmd;
        n_cmd_cnt   = r_cmd_cnt;
        n_idle      = r_idle;
        n_app       = r_app;
        n_sr        = r_sr;
        n_pos       = r_pos;
        n_len       = r_len;
        n_sblk      = r_sblk;
        n_blk       = r_blk;
        n_dcnt      = r_dcnt;
        n_rd_pend   = 1'b0;
        mem_req     = '0;
        b           = sdst_pkg::IDLE_BYTE;
        rise        = s_axis_tdata[1] && !r_last_clk;
        byte_done   = 1'b0;
        in_byte     = {r_in_shift[6:0], s_axis_tdata[2]};
        idx         = r_cmd[0][5:0];
        arg         = {r_cmd[1], r_cmd[2], r_cmd[3], r_cmd[4]};
        r1v         = r_idle ? sdst_pkg::R1_IDLE : 8'h00;
        pos_inc     = r_pos + 10'd1;
        pos_m2      = r_pos - 10'd2;
        rd_addr     = {1'b0, r_blk} + {23'd0, pos_m2};
        wr_addr     = {1'b0, r_blk} + {23'd0, r_dcnt};
        wr_end      = {1'b0, r_blk} + 33'(sdst_pkg::BLK);
        fits        = wr_end <= SB;

        if (accept) begin
            n_last_clk = s_axis_tdata[1];
            if (!r_present || s_axis_tdata[0]) begin
                n_bit_cnt   = 3'd0;
                n_out_level = 1'b1;
            end else if (rise) begin
                n_out_level = n_out_shift[7];
                n_out_shift = {n_out_shift[6:0], 1'b1};
                n_in_shift  = in_byte;
                n_bit_cnt   = r_bit_cnt + 3'd1;
                byte_done   = (r_bit_cnt == 3'd7);
            end
        end

        // one received byte
        if (byte_done) begin
            n_in_shift = 8'h00;
            case (r_phase)
                sdst_pkg::PH_SEND: begin
                    if (r_pos < 10'd2 || (!r_sblk && r_pos < 10'd5)) begin
                        b = r_sr[r_pos[2:0]];
                    end else if (r_sblk && r_pos < 10'(sdst_pkg::BLK + 2)) begin
                        if (rd_addr < SB) begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = rd_addr[31:0];
                            n_rd_pend     = 1'b1;
                        end else begin
                            b = 8'h00;
                        end
                    end
                    n_pos = pos_inc;
                    if (pos_inc >= r_len) begin
                        n_pos   = '0;
                        n_len   = '0;
                        n_sblk  = 1'b0;
                        n_phase = r_after;
                    end
                end
                sdst_pkg::PH_TOKEN: begin
                    if (in_byte == sdst_pkg::TOK_START) begin
                        n_dcnt  = '0;
                        n_phase = sdst_pkg::PH_DATA;
                    end
                end
                sdst_pkg::PH_DATA: begin
                    if (r_dcnt < 10'(sdst_pkg::BLK) && fits) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = wr_addr[31:0];
                        mem_req.wdata = in_byte;
                    end
                    n_dcnt = r_dcnt + 10'd1;
                    if (n_dcnt >= 10'(sdst_pkg::BLK + 2)) begin
                        n_sr[0] = fits ? sdst_pkg::DR_OK : sdst_pkg::DR_WR_ERR;
                        n_sr[1] = 8'h00;
                        n_sr[2] = 8'h00;
                        n_sr[3] = 8'hFF;
                        n_sblk  = 1'b0;
                        n_len   = 10'd4;
                        n_pos   = '0;
                        n_after = sdst_pkg::PH_CMD;
                        n_phase = sdst_pkg::PH_SEND;
                    end
                end
                default: begin
                    if (!(r_cmd_cnt == 3'd0 && in_byte[7:6] != 2'b01)) begin
                        n_cmd[r_cmd_cnt] = in_byte;
                        n_cmd_cnt        = r_cmd_cnt + 3'd1;
                        if (r_cmd_cnt == 3'd5) begin
                            n_cmd_cnt = 3'd0;
                            n_app     = 1'b0;
                            // default reply is a single r1 byte
                            n_sblk    = 1'b0;
                            n_len     = 10'd1;
                            n_pos     = '0;
                            n_after   = sdst_pkg::PH_CMD;
                            n_phase   = sdst_pkg::PH_SEND;
                            if (r_app && idx == sdst_pkg::ACMD_OP_COND) begin
                                n_idle  = 1'b0;
                                n_sr[0] = 8'h00;
                            end else begin
                                case (idx)
                                    sdst_pkg::CMD_GO_IDLE: begin
                                        n_idle  = 1'b1;
                                        n_sr[0] = sdst_pkg::R1_IDLE;
                                    end
                                    sdst_pkg::CMD_OP_COND: begin
                                        n_idle  = 1'b0;
                                        n_sr[0] = 8'h00;
                                    end
                                    sdst_pkg::CMD_BLK_LEN: begin
                                        n_sr[0] = 8'h00;
                                    end
                                    sdst_pkg::CMD_RD_SINGLE: begin
                                        n_blk   = arg;
                                        n_sr[0] = 8'h00;
                                        if ({1'b0, arg} >= SB) begin
                                            n_sr[1] = sdst_pkg::TOK_RD_ERR;
                                            n_len   = 10'd2;
                                        end else begin
                                            n_sr[1] = sdst_pkg::TOK_START;
                                            n_sblk  = 1'b1;
                                            n_len   = 10'(sdst_pkg::BLK + 4);
                                        end
                                    end
                                    sdst_pkg::CMD_WR_SINGLE: begin
                                        n_blk   = arg;
                                        n_sr[0] = 8'h00;
                                        n_after = sdst_pkg::PH_TOKEN;
                                    end
                                    sdst_pkg::CMD_APP: begin
                                        n_app   = 1'b1;
                                        n_sr[0] = r1v;
                                    end
                                    sdst_pkg::CMD_RD_OCR: begin
                                        n_sr[0] = r1v;
                                        n_sr[1] = sdst_pkg::OCR_VALUE[31:24];
                                        n_sr[2] = sdst_pkg::OCR_VALUE[23:16];
                                        n_sr[3] = sdst_pkg::OCR_VALUE[15:8];
                                        n_sr[4] = sdst_pkg::OCR_VALUE[7:0];
                                        n_len   = 10'd5;
                                    end
                                    default: begin
                                        n_sr[0] = r1v | sdst_pkg::R1_ILLEGAL;
                                    end
                                endcase
                            end
                        end
                    end
                end
            endcase
            if (!n_rd_pend) begin
                n_out_shift = b;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= 1'b1;
            r_last_clk  <= 1'b0;
            r_out_level <= 1'b1;
            r_bit_cnt   <= '0;
            r_in_shift  <= '0;
            r_out_shift <= sdst_pkg::IDLE_BYTE;
            r_phase     <= sdst_pkg::PH_CMD;
            r_after     <= sdst_pkg::PH_CMD;
            r_cmd       <= '{default: 8'h00};
            r_cmd_cnt   <= '0;
            r_idle      <= 1'b1;
            r_app       <= 1'b0;
            r_sr        <= '{default: 8'h00};
            r_pos       <= '0;
            r_len       <= '0;
            r_sblk      <= 1'b0;
            r_blk       <= '0;
            r_dcnt      <= '0;
            r_rd_pend   <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_present <= i_cfg_data;
            end
            r_last_clk  <= n_last_clk;
            r_out_level <= n_out_level;
            r_bit_cnt   <= n_bit_cnt;
            r_in_shift  <= n_in_shift;
            r_out_shift <= n_out_shift;
            r_phase     <= n_phase;
            r_after     <= n_after;
            r_cmd       <= n_cmd;
            r_cmd_cnt   <= n_cmd_cnt;
            r_idle      <= n_idle;
            r_app       <= n_app;
            r_sr        <= n_sr;
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_sblk      <= n_sblk;
            r_blk       <= n_blk;
            r_dcnt      <= n_dcnt;
            r_rd_pend   <= n_rd_pend;
            if (accept) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_odata <= n_out_level;
        end
    end

endmodule

### design/sdst_store.sv
// card byte store with clearing sweep after reset and registered read
module sdst_store #(
    parameter longint unsigned STORE_BYTES = sdst_pkg::STORE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sdst_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata,
    output logic              o_busy
);
    localparam int AW = $clog2(STORE_BYTES);

    logic [7:0]    r_mem [0:STORE_BYTES-1];
    logic [AW-1:0] r_clr_cnt;
    logic          r_busy;
    logic [7:0]    r_rdata;

    // clearing sweep, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_busy    <= 1'b1;
        end else if (r_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == AW'(STORE_BYTES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // single write port shared by sweep and engine
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_cnt] <= 8'h00;
        end else if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

### design/sdst_checker.sv
// port-level checks of the card target, bound to the top level
`include "sd_card_spi_mode_target_assert.svh"

module sdst_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    // every taken sample yields a word next cycle
    `SDST_AST_NEXT(a_word_follows, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "no word after sample")
    // deselected sample drives data_out high
    `SDST_AST_NEXT(a_desel_high, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tdata[0], m_axis_tdata[0], "data_out low while deselected")
    // no sample taken while a word is stalled
    `SDST_AST_SAME(a_no_overrun, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "sample taken over stalled word")
    // padding bits stay zero
    `SDST_AST_SAME(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[7:1] == 7'd0, "nonzero padding")
endmodule

bind sd_card_spi_mode_target sdst_checker u_sdst_checker (.*);
